>>> src/ddsg_pkg.sv
// Shared types and constants for the DDS step/direction generator.
// No dependencies; compiled first.
`default_nettype none

package ddsg_pkg;

    // Default configuration of the generator
    localparam int DEF_AXES           = 4;
    localparam int DEF_ACC_WIDTH      = 32;
    localparam int DEF_STEP_BIT_INDEX = 16;

    // Fixed item layout
    localparam int FUNC_WIDTH = 2;
    localparam int VEL_WIDTH  = 32;
    localparam int POS_WIDTH  = 32;
    localparam int PORT_AXES  = 4;
    localparam int WIDE_WIDTH = 64;

    typedef logic [FUNC_WIDTH-1:0]       func_t;
    typedef logic signed [VEL_WIDTH-1:0] vel_t;
    typedef logic signed [POS_WIDTH-1:0] pos_t;
    typedef logic [PORT_AXES-1:0]        levels_t;

    // Item function codes; the fourth code does nothing
    localparam func_t FUNC_TICK  = 2'd0;
    localparam func_t FUNC_LOAD  = 2'd1;
    localparam func_t FUNC_CLEAR = 2'd2;

endpackage

`default_nettype wire

>>> src/ddsg_if.sv
// Valid/ready channels of the step/direction generator: command and result.
// Depends on ddsg_pkg.
`default_nettype none

interface ddsg_cmd_if;
    import ddsg_pkg::*;

    logic  valid;
    logic  ready;
    func_t func;
    vel_t  vel_x;
    vel_t  vel_y;
    vel_t  vel_z;
    vel_t  vel_a;

    modport source (output valid, output func, output vel_x, output vel_y,
                    output vel_z, output vel_a, input ready);
    modport sink   (input valid, input func, input vel_x, input vel_y,
                    input vel_z, input vel_a, output ready);
endinterface

interface ddsg_res_if;
    import ddsg_pkg::*;

    logic    valid;
    logic    ready;
    levels_t step_levels;
    levels_t dir_levels;
    pos_t    pos_x;
    pos_t    pos_y;
    pos_t    pos_z;
    pos_t    pos_a;

    modport source (output valid, output step_levels, output dir_levels,
                    output pos_x, output pos_y, output pos_z, output pos_a,
                    input ready);
    modport sink   (input valid, input step_levels, input dir_levels,
                    input pos_x, input pos_y, input pos_z, input pos_a,
                    output ready);
endinterface

`default_nettype wire

>>> src/dds_step_dir_generator.sv
// Phase-accumulator step/direction generator for AXES axes.
// Depends on ddsg_pkg and the channel interfaces in ddsg_if.
//
// Each command item is a tick, a velocity load, a reset of all axes or the unused
// code, which holds everything. A tick toggles an axis's step output whenever the
// accumulator's step bit differs from the copy taken at its last toggle, then adds
// the signed velocity to the accumulator. Direction follows the velocity's sign at
// the falling edge of step (1 = negative, held for zero velocity). Every command
// item yields exactly one result item with step levels, direction levels and the
// low 32 bits of the first four accumulators, in the cycle after it is taken.
// The block takes one item per clock while its results are taken: all per-axis work
// is one add and one compare between the axis state registers and the result register,
// and a waiting result is overwritten only when it is taken in the same cycle.
`default_nettype none

module dds_step_dir_generator #(
    parameter int AXES           = ddsg_pkg::DEF_AXES,
    parameter int ACC_WIDTH      = ddsg_pkg::DEF_ACC_WIDTH,
    parameter int STEP_BIT_INDEX = ddsg_pkg::DEF_STEP_BIT_INDEX
) (
    input  wire         clk,
    input  wire         rst_n,
    ddsg_cmd_if.sink    cmd,
    ddsg_res_if.source  result
);
    import ddsg_pkg::*;

    localparam bit STEP_IN_RANGE = (STEP_BIT_INDEX < ACC_WIDTH);
    localparam int STEP_POS      = STEP_IN_RANGE ? STEP_BIT_INDEX : 0;

    typedef logic [ACC_WIDTH-1:0] acc_t;

    // Per-axis state
    acc_t        accum_reg      [AXES];
    vel_t        vel_reg        [AXES];
    logic [AXES-1:0] last_bit_reg;
    logic [AXES-1:0] last_sign_reg;
    logic [AXES-1:0] next_high_reg;
    logic [AXES-1:0] step_reg;
    logic [AXES-1:0] dir_reg;

    acc_t        accum_next     [AXES];
    vel_t        vel_next       [AXES];
    logic [AXES-1:0] last_bit_next;
    logic [AXES-1:0] last_sign_next;
    logic [AXES-1:0] next_high_next;
    logic [AXES-1:0] step_next;
    logic [AXES-1:0] dir_next;

    // Result register
    logic    res_valid_reg;
    levels_t res_step_reg;
    levels_t res_dir_reg;
    pos_t    res_pos_reg  [PORT_AXES];
    levels_t res_step_next;
    levels_t res_dir_next;
    pos_t    res_pos_next [PORT_AXES];

    vel_t    vel_in   [PORT_AXES];
    vel_t    vel_load [AXES];
    logic    cmd_fire;

    assign cmd.ready = !res_valid_reg || result.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign vel_in[0] = cmd.vel_x;
    assign vel_in[1] = cmd.vel_y;
    assign vel_in[2] = cmd.vel_z;
    assign vel_in[3] = cmd.vel_a;

    // Axes past the fourth load zero velocity
    for (genvar g = 0; g < AXES; g++) begin : g_load
        if (g < PORT_AXES) begin : g_port
            assign vel_load[g] = vel_in[g];
        end
        else begin : g_extra
            assign vel_load[g] = '0;
        end
    end

    // Advance all axes for one item
    always_comb
    begin
        logic [WIDE_WIDTH-1:0] vel_wide;
        logic                  bit_now;
        logic                  toggle;
        logic                  sign;
        for (int a = 0; a < AXES; a++)
        begin
            accum_next[a]     = accum_reg[a];
            vel_next[a]       = vel_reg[a];
            last_bit_next[a]  = last_bit_reg[a];
            last_sign_next[a] = last_sign_reg[a];
            next_high_next[a] = next_high_reg[a];
            step_next[a]      = step_reg[a];
            dir_next[a]       = dir_reg[a];

            vel_wide = WIDE_WIDTH'(vel_reg[a]);
            bit_now  = STEP_IN_RANGE ? accum_reg[a][STEP_POS] : 1'b0;
            toggle   = (bit_now != last_bit_reg[a]);
            sign     = vel_reg[a][VEL_WIDTH-1];

            unique case (cmd.func)
                FUNC_TICK:
                begin
                    if (toggle)
                    begin
                        last_bit_next[a]  = bit_now;
                        next_high_next[a] = !next_high_reg[a];
                        step_next[a]      = next_high_reg[a];
                    end
                    accum_next[a] = accum_reg[a] + vel_wide[ACC_WIDTH-1:0];
                    // Falling edge of step: follow a changed velocity sign
                    if (toggle && !next_high_reg[a] && (sign != last_sign_reg[a]))
                    begin
                        last_sign_next[a] = sign;
                        if (sign)
                        begin
                            dir_next[a] = 1'b1;
                        end
                        else if (vel_reg[a] != '0)
                        begin
                            dir_next[a] = 1'b0;
                        end
                    end
                end
                FUNC_LOAD:
                begin
                    vel_next[a] = vel_load[a];
                end
                FUNC_CLEAR:
                begin
                    accum_next[a]     = '0;
                    vel_next[a]       = '0;
                    last_bit_next[a]  = 1'b0;
                    last_sign_next[a] = 1'b0;
                    next_high_next[a] = 1'b1;
                    step_next[a]      = 1'b0;
                    dir_next[a]       = 1'b0;
                end
                default:
                begin
                    // Unused code: hold everything
                end
            endcase
        end
    end

    // Map the first four axes onto the result fields
    for (genvar g = 0; g < PORT_AXES; g++) begin : g_out
        if (g < AXES) begin : g_live
            logic [WIDE_WIDTH-1:0] acc_wide;
            assign acc_wide         = WIDE_WIDTH'(accum_next[g]);
            assign res_pos_next[g]  = acc_wide[POS_WIDTH-1:0];
            assign res_step_next[g] = step_next[g];
            assign res_dir_next[g]  = dir_next[g];
        end
        else begin : g_none
            assign res_pos_next[g]  = '0;
            assign res_step_next[g] = 1'b0;
            assign res_dir_next[g]  = 1'b0;
        end
    end

    // Hold axis state; advance on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                accum_reg[a] <= '0;
                vel_reg[a]   <= '0;
            end
            last_bit_reg  <= '0;
            last_sign_reg <= '0;
            next_high_reg <= '1;
            step_reg      <= '0;
            dir_reg       <= '0;
        end
        else if (cmd_fire)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                accum_reg[a] <= accum_next[a];
                vel_reg[a]   <= vel_next[a];
            end
            last_bit_reg  <= last_bit_next;
            last_sign_reg <= last_sign_next;
            next_high_reg <= next_high_next;
            step_reg      <= step_next;
            dir_reg       <= dir_next;
        end
    end

    // Result valid: set by an accepted item, dropped when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            res_step_reg <= res_step_next;
            res_dir_reg  <= res_dir_next;
            for (int o = 0; o < PORT_AXES; o++)
            begin
                res_pos_reg[o] <= res_pos_next[o];
            end
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.step_levels = res_step_reg;
    assign result.dir_levels  = res_dir_reg;
    assign result.pos_x       = res_pos_reg[0];
    assign result.pos_y       = res_pos_reg[1];
    assign result.pos_z       = res_pos_reg[2];
    assign result.pos_a       = res_pos_reg[3];

endmodule

`default_nettype wire

>>> src/ddsg_checker.sv
// Port-level checks for the step/direction generator, bound to its top level.
// Depends on ddsg_pkg and dds_step_dir_generator.
`default_nettype none

module ddsg_checker (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cmd_valid,
    input  wire                cmd_ready,
    input  wire [1:0]          cmd_func,
    input  wire                res_valid,
    input  wire                res_ready,
    input  wire [3:0]          res_step,
    input  wire [3:0]          res_dir,
    input  wire [31:0]         res_pos_x,
    input  wire [31:0]         res_pos_y,
    input  wire [31:0]         res_pos_z,
    input  wire [31:0]         res_pos_a
);
    import ddsg_pkg::*;

    // Every accepted item shows a result in the next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> res_valid)
        else $error("accepted item produced no result");

    // An empty result register never blocks the command side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> cmd_ready)
        else $error("command stalled with no result pending");

    // A reset item reports cleared axes
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_func == FUNC_CLEAR) |=>
            (res_step == 4'd0) && (res_dir == 4'd0) && (res_pos_x == 32'd0) &&
            (res_pos_y == 32'd0) && (res_pos_z == 32'd0) && (res_pos_a == 32'd0))
        else $error("reset item left state behind");

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_step) &&
            $stable(res_dir) && $stable(res_pos_x) && $stable(res_pos_y) &&
            $stable(res_pos_z) && $stable(res_pos_a))
        else $error("stalled result changed");

endmodule

bind dds_step_dir_generator ddsg_checker u_ddsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd_func  (cmd.func),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_step  (result.step_levels),
    .res_dir   (result.dir_levels),
    .res_pos_x (result.pos_x),
    .res_pos_y (result.pos_y),
    .res_pos_z (result.pos_z),
    .res_pos_a (result.pos_a)
);

`default_nettype wire

>>> sim/dds_step_dir_generator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the four-axis step/direction generator.
// Depends on ddsg_pkg, the channel interfaces and dds_step_dir_generator.

module dds_step_dir_generator_tb;
    import ddsg_pkg::*;

    localparam int ACC_W       = DEF_ACC_WIDTH;
    localparam int STEP_BIT    = DEF_STEP_BIT_INDEX;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_CMDS = 450;
    localparam int QUIET_CMDS  = 60;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 80;

    // The fourth function code leaves the generator untouched
    localparam func_t FUNC_UNUSED = 2'd3;

    typedef struct packed {
        func_t func;
        vel_t  vel_x;
        vel_t  vel_y;
        vel_t  vel_z;
        vel_t  vel_a;
    } motion_cmd_t;

    typedef struct packed {
        levels_t step_levels;
        levels_t dir_levels;
        pos_t    pos_x;
        pos_t    pos_y;
        pos_t    pos_z;
        pos_t    pos_a;
    } axis_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ddsg_cmd_if cmd_ch ();
    ddsg_res_if res_ch ();

    dds_step_dir_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    always #4 clk = ~clk;

    motion_cmd_t  cmd_pending [$];
    axis_report_t expected_reports [$];

    int cmd_total = 0;
    int cmd_accepted = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic quiet;

    motion_cmd_t  next_cmd;
    motion_cmd_t  seen_cmd;
    axis_report_t predicted;
    axis_report_t observed;

    // Shadow copy of the per-axis generator state
    logic [ACC_W-1:0]     acc_q   [PORT_AXES];
    vel_t                 vel_q   [PORT_AXES];
    logic [PORT_AXES-1:0] last_step_q;
    logic [PORT_AXES-1:0] last_sign_q;
    logic [PORT_AXES-1:0] want_high_q;
    logic [PORT_AXES-1:0] step_q;
    logic [PORT_AXES-1:0] dir_q;

    assign quiet = (cmd_accepted >= cmd_total - QUIET_CMDS);

    task automatic clear_axes();
        for (int i = 0; i < PORT_AXES; i++)
        begin
            acc_q[i] = '0;
            vel_q[i] = '0;
        end
        last_step_q = '0;
        last_sign_q = '0;
        want_high_q = '1;
        step_q      = '0;
        dir_q       = '0;
    endtask

    // Apply one command to the shadow state and build the report it yields
    task automatic predict_report(input motion_cmd_t c, output axis_report_t r);
        vel_t in_vel [PORT_AXES];
        logic step_now;
        logic toggles;
        logic sign_now;
        in_vel = '{c.vel_x, c.vel_y, c.vel_z, c.vel_a};
        case (c.func)
            FUNC_TICK:
            begin
                for (int i = 0; i < PORT_AXES; i++)
                begin
                    step_now = acc_q[i][STEP_BIT];
                    toggles  = (step_now != last_step_q[i]);
                    sign_now = vel_q[i][VEL_WIDTH-1];
                    if (toggles)
                    begin
                        last_step_q[i] = step_now;
                        step_q[i]      = want_high_q[i];
                        want_high_q[i] = ~want_high_q[i];
                    end
                    acc_q[i] = acc_q[i] + ACC_W'(vel_q[i]);
                    // Direction only follows the sign on a falling step edge
                    if (toggles && want_high_q[i] && sign_now != last_sign_q[i])
                    begin
                        last_sign_q[i] = sign_now;
                        if (sign_now)
                            dir_q[i] = 1'b1;
                        else if (vel_q[i] != 0)
                            dir_q[i] = 1'b0;
                    end
                end
            end
            FUNC_LOAD:
            begin
                for (int i = 0; i < PORT_AXES; i++)
                    vel_q[i] = in_vel[i];
            end
            FUNC_CLEAR:
                clear_axes();
            default:
                ;
        endcase
        r.step_levels = step_q;
        r.dir_levels  = dir_q;
        r.pos_x       = acc_q[0][POS_WIDTH-1:0];
        r.pos_y       = acc_q[1][POS_WIDTH-1:0];
        r.pos_z       = acc_q[2][POS_WIDTH-1:0];
        r.pos_a       = acc_q[3][POS_WIDTH-1:0];
    endtask

    function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            if (mismatch_count < 10)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic vel_t pick_velocity();
        vel_t v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7fff_ffff;
                    1: v = 32'sh8000_0000;
                    2: v = -32'sd1;
                    default: v = 32'sd1;
                endcase
            end
            2, 3: v = $urandom;
            default:
            begin
                v = $urandom_range(32'h800, 32'h30000);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic add_cmd(input func_t f, input vel_t x, input vel_t y, input vel_t z,
                           input vel_t a);
        motion_cmd_t c;
        c.func  = f;
        c.vel_x = x;
        c.vel_y = y;
        c.vel_z = z;
        c.vel_a = a;
        cmd_pending.push_back(c);
    endtask

    task automatic add_random_cmd(input func_t f);
        add_cmd(f, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Offer pending items; hold each one until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.func  <= FUNC_TICK;
            cmd_ch.vel_x <= '0;
            cmd_ch.vel_y <= '0;
            cmd_ch.vel_z <= '0;
            cmd_ch.vel_a <= '0;
            send_gap     <= 0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (send_gap != 0)
            begin
                send_gap     <= send_gap - 1;
                cmd_ch.valid <= 1'b0;
            end
            else if (cmd_pending.size() != 0)
            begin
                next_cmd = cmd_pending.pop_front();
                cmd_ch.func  <= next_cmd.func;
                cmd_ch.vel_x <= next_cmd.vel_x;
                cmd_ch.vel_y <= next_cmd.vel_y;
                cmd_ch.vel_z <= next_cmd.vel_z;
                cmd_ch.vel_a <= next_cmd.vel_a;
                cmd_ch.valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 7);
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // Hold off the result channel once for a long stretch to back up the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && cmd_accepted >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Stall the result channel in short random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (hold_left != 0)
            res_ch.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left   <= $urandom_range(0, 6);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Predict on every accepted command, check every accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_axes();
            cmd_accepted <= 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                seen_cmd.func  = cmd_ch.func;
                seen_cmd.vel_x = cmd_ch.vel_x;
                seen_cmd.vel_y = cmd_ch.vel_y;
                seen_cmd.vel_z = cmd_ch.vel_z;
                seen_cmd.vel_a = cmd_ch.vel_a;
                predict_report(seen_cmd, predicted);
                expected_reports.push_back(predicted);
                cmd_accepted <= cmd_accepted + 1;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                observed.step_levels = res_ch.step_levels;
                observed.dir_levels  = res_ch.dir_levels;
                observed.pos_x       = res_ch.pos_x;
                observed.pos_y       = res_ch.pos_y;
                observed.pos_z       = res_ch.pos_z;
                observed.pos_a       = res_ch.pos_a;
                if (expected_reports.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: result item with nothing expected", $realtime);
                    mismatch_count++;
                end
                else
                begin
                    predicted = expected_reports.pop_front();
                    if (field_differs("step_levels", 32'(predicted.step_levels),
                                      32'(observed.step_levels))
                        | field_differs("dir_levels", 32'(predicted.dir_levels),
                                        32'(observed.dir_levels))
                        | field_differs("pos_x", predicted.pos_x, observed.pos_x)
                        | field_differs("pos_y", predicted.pos_y, observed.pos_y)
                        | field_differs("pos_z", predicted.pos_z, observed.pos_z)
                        | field_differs("pos_a", predicted.pos_a, observed.pos_a))
                        mismatch_count++;
                end
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int ticks;
        cmd_ch.valid = 1'b0;
        cmd_ch.func  = FUNC_TICK;
        cmd_ch.vel_x = '0;
        cmd_ch.vel_y = '0;
        cmd_ch.vel_z = '0;
        cmd_ch.vel_a = '0;
        res_ch.ready = 1'b0;

        // Directed: idle tick, unused code, extreme velocities, clear
        add_cmd(FUNC_TICK, '0, '0, '0, '0);
        add_random_cmd(FUNC_UNUSED);
        add_cmd(FUNC_LOAD, 32'sh7fff_ffff, 32'sh8000_0000, '0, -32'sd1);
        repeat (3) add_cmd(FUNC_TICK, '0, '0, '0, '0);
        add_cmd(FUNC_CLEAR, '0, '0, '0, '0);
        // Directed: step toggling and direction on falling edges
        add_cmd(FUNC_LOAD, 32'sh8000, -32'sh8000, 32'sh1_0000, 32'sh3000);
        repeat (8) add_cmd(FUNC_TICK, '0, '0, '0, '0);
        // Directed: zero velocity keeps direction, sign reversal flips it
        add_cmd(FUNC_LOAD, -32'sh9000, '0, '0, 32'sh5000);
        repeat (4) add_cmd(FUNC_TICK, '0, '0, '0, '0);
        add_random_cmd(FUNC_UNUSED);
        add_cmd(FUNC_CLEAR, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        add_cmd(FUNC_TICK, -32'sd1, -32'sd1, -32'sd1, -32'sd1);

        // Random: mostly velocity loads followed by runs of ticks
        ticks = cmd_pending.size();
        while (cmd_pending.size() < ticks + RANDOM_CMDS)
        begin
            case ($urandom_range(0, 19))
                0: add_random_cmd(FUNC_CLEAR);
                1: add_random_cmd(FUNC_UNUSED);
                2: add_random_cmd(FUNC_LOAD);
                default:
                begin
                    add_cmd(FUNC_LOAD, pick_velocity(), pick_velocity(), pick_velocity(),
                            pick_velocity());
                    repeat ($urandom_range(5, 30)) add_random_cmd(FUNC_TICK);
                end
            endcase
        end
        cmd_total = cmd_pending.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_accepted != cmd_total)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (expected_reports.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
